FILE: sv/lgsf_pkg.sv
// lgsf_pkg: shared constants, command codes and controller/datapath structs
// for the linear gradient span painter. No dependencies.
package lgsf_pkg;

  localparam int RAMP_BITS_DEF  = 10;
  localparam int SCALE_BITS_DEF = 16;
  localparam int STOP_SLOTS_DEF = 16;
  localparam int MAX_RUN_DEF    = 64;

  localparam int FUNC_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int COLOR_W    = 32;
  localparam int COORD_W    = 16;
  localparam int COUNT_W    = 7;
  localparam int POS_W      = 10;
  localparam int SIDX_W     = 4;
  localparam int TDATA_W    = 88;

  // input tdata layout, lowest bit first
  localparam int OFS_SIDX   = 0;
  localparam int OFS_SVALID = 4;
  localparam int OFS_SPOS   = 5;
  localparam int OFS_SCOL   = 15;
  localparam int OFS_X      = 47;
  localparam int OFS_Y      = 63;
  localparam int OFS_COUNT  = 79;

  localparam logic [FUNC_W-1:0] FUNC_WRITE_STOP = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REBUILD    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PAINT      = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NOP        = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPREAD = 2'd3;

  localparam logic [1:0] SPREAD_PAD     = 2'd0;
  localparam logic [1:0] SPREAD_REPEAT  = 2'd1;
  localparam logic [1:0] SPREAD_REFLECT = 2'd2;

  localparam logic [COLOR_W-1:0] COLOR_WHITE = 32'hFFFF_FFFF;
  localparam logic [7:0]         CH_MAX      = 8'hFF;

  typedef struct packed {
    logic accept;
    logic wr_stop;
    logic clr_wr;
    logic load_cur;
    logic fill_wr;
    logic load_nxt;
    logic adv;
    logic div_start;
    logic div_step;
    logic mul;
    logic blend_wr;
    logic pt_mul;
    logic pt_sum;
    logic pt_issue;
  } cmd_t;

  typedef struct packed {
    logic rd_end;
    logic i_eq_cur;
    logic i_eq_nxt;
    logic i_max;
    logic nxt_end;
    logic nxt_gt;
    logic div_last;
    logic cnt_zero;
    logic cnt_one;
    logic credit;
  } sts_t;

endpackage

FILE: sv/lgsf_ram.sv
// lgsf_ram: generic single write port, single read port RAM with registered
// read data. No dependencies.
module lgsf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/lgsf_ctrl.sv
// lgsf_ctrl: sequencer for table clear, stop writes, ramp rebuild and span
// painting. Depends on lgsf_pkg; drives the datapath through cmd_t.
module lgsf_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_tvalid_i,
  input  logic [lgsf_pkg::FUNC_W-1:0]   s_tuser_i,
  output logic                          s_tready_o,
  input  lgsf_pkg::sts_t                sts_i,
  output lgsf_pkg::cmd_t                cmd_o
);
  import lgsf_pkg::*;

  localparam logic [3:0] ST_CLEAR    = 4'd0;
  localparam logic [3:0] ST_IDLE     = 4'd1;
  localparam logic [3:0] ST_RB_FIRST = 4'd2;
  localparam logic [3:0] ST_RB_FILL  = 4'd3;
  localparam logic [3:0] ST_RB_LOADN = 4'd4;
  localparam logic [3:0] ST_RB_DEC   = 4'd5;
  localparam logic [3:0] ST_RB_DIV   = 4'd6;
  localparam logic [3:0] ST_RB_MUL   = 4'd7;
  localparam logic [3:0] ST_RB_WR    = 4'd8;
  localparam logic [3:0] ST_RB_TAIL  = 4'd9;
  localparam logic [3:0] ST_PT_MUL   = 4'd10;
  localparam logic [3:0] ST_PT_SUM   = 4'd11;
  localparam logic [3:0] ST_PT_RUN   = 4'd12;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.i_max) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.accept = 1'b1;
          unique case (s_tuser_i)
            FUNC_WRITE_STOP: cmd_o.wr_stop = 1'b1;
            FUNC_REBUILD:    state_d = ST_RB_FIRST;
            FUNC_PAINT:      state_d = ST_PT_MUL;
            default:         state_d = ST_IDLE;
          endcase
        end
      end
      ST_RB_FIRST: begin
        // leave the table alone when slot 0 ends the list
        if (sts_i.rd_end) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.load_cur = 1'b1;
          state_d = ST_RB_FILL;
        end
      end
      ST_RB_FILL: begin
        cmd_o.fill_wr = 1'b1;
        if (sts_i.i_eq_cur) state_d = ST_RB_LOADN;
      end
      ST_RB_LOADN: begin
        cmd_o.load_nxt = 1'b1;
        state_d = ST_RB_DEC;
      end
      ST_RB_DEC: begin
        if (sts_i.nxt_end) begin
          state_d = ST_RB_TAIL;
        end else if (sts_i.nxt_gt) begin
          cmd_o.div_start = 1'b1;
          state_d = ST_RB_DIV;
        end else begin
          cmd_o.adv = 1'b1;
          state_d = ST_RB_LOADN;
        end
      end
      ST_RB_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = ST_RB_MUL;
      end
      ST_RB_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = ST_RB_WR;
      end
      ST_RB_WR: begin
        cmd_o.blend_wr = 1'b1;
        if (sts_i.i_eq_nxt) begin
          cmd_o.adv = 1'b1;
          state_d = ST_RB_LOADN;
        end else begin
          state_d = ST_RB_MUL;
        end
      end
      ST_RB_TAIL: begin
        cmd_o.fill_wr = 1'b1;
        if (sts_i.i_max) state_d = ST_IDLE;
      end
      ST_PT_MUL: begin
        cmd_o.pt_mul = 1'b1;
        state_d = ST_PT_SUM;
      end
      ST_PT_SUM: begin
        cmd_o.pt_sum = 1'b1;
        state_d = ST_PT_RUN;
      end
      ST_PT_RUN: begin
        if (sts_i.cnt_zero) begin
          state_d = ST_IDLE;
        end else if (sts_i.credit) begin
          cmd_o.pt_issue = 1'b1;
          if (sts_i.cnt_one) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: sv/lgsf_dp.sv
// lgsf_dp: config registers, stop store, ramp table, segment divider and
// blender, gradient accumulator and output queue. Depends on lgsf_pkg, lgsf_ram.
module lgsf_dp #(
  parameter int RAMP_BITS  = lgsf_pkg::RAMP_BITS_DEF,
  parameter int SCALE_BITS = lgsf_pkg::SCALE_BITS_DEF,
  parameter int STOP_SLOTS = lgsf_pkg::STOP_SLOTS_DEF,
  parameter int MAX_RUN    = lgsf_pkg::MAX_RUN_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lgsf_pkg::cmd_t                    cmd_i,
  output lgsf_pkg::sts_t                    sts_o,
  input  logic [lgsf_pkg::TDATA_W-1:0]      in_data_i,
  input  logic                              cfg_we_i,
  input  logic [lgsf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lgsf_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output logic                              m_tvalid_o,
  input  logic                              m_tready_i,
  output logic [lgsf_pkg::COLOR_W-1:0]      m_tdata_o,
  output logic                              m_tlast_o
);
  import lgsf_pkg::*;

  localparam int RampDepth = 1 << RAMP_BITS;
  localparam int RampMax   = RampDepth - 1;
  localparam int SlotW     = (STOP_SLOTS > 1) ? $clog2(STOP_SLOTS) : 1;
  localparam int PtrW      = $clog2(STOP_SLOTS + 1);
  localparam int Sh        = SCALE_BITS - RAMP_BITS;
  localparam int IdxW      = 32 + ((Sh < 0) ? -Sh : 0);
  localparam int RunW      = $clog2(MAX_RUN + 1);
  localparam int PosCmpW   = ((RAMP_BITS > POS_W) ? RAMP_BITS : POS_W) + 1;

  // input fields
  logic [SIDX_W-1:0]  in_sidx;
  logic               in_svalid;
  logic [POS_W-1:0]   in_spos;
  logic [COLOR_W-1:0] in_scol;
  assign in_sidx   = in_data_i[OFS_SIDX +: SIDX_W];
  assign in_svalid = in_data_i[OFS_SVALID];
  assign in_spos   = in_data_i[OFS_SPOS +: POS_W];
  assign in_scol   = in_data_i[OFS_SCOL +: COLOR_W];

  // configuration
  logic signed [31:0] step_x_q, step_y_q, offset_q;
  logic [1:0]         spread_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_x_q <= '0;
      step_y_q <= '0;
      offset_q <= '0;
      spread_q <= SPREAD_PAD;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_STEP_X: step_x_q <= cfg_data_i;
        CFG_STEP_Y: step_y_q <= cfg_data_i;
        CFG_OFFSET: offset_q <= cfg_data_i;
        CFG_SPREAD: spread_q <= cfg_data_i[1:0];
        default:    spread_q <= spread_q;
      endcase
    end
  end

  // stop store: bit POS_W of a position marks the end of the list
  logic [POS_W:0]      stop_pos_q [STOP_SLOTS];
  logic [COLOR_W-1:0]  stop_col_q [STOP_SLOTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < STOP_SLOTS; k++) begin
        stop_pos_q[k] <= (k == 0) ? '0 :
                         (k == 1) ? {1'b0, POS_W'(RampMax)} : {1'b1, {POS_W{1'b0}}};
        stop_col_q[k] <= (k < 2) ? COLOR_WHITE : '0;
      end
    end else if (cmd_i.wr_stop && (int'(in_sidx) < STOP_SLOTS)) begin
      if (in_svalid) begin
        stop_pos_q[SlotW'(in_sidx)] <= {1'b0, in_spos};
        stop_col_q[SlotW'(in_sidx)] <= in_scol;
      end else begin
        stop_pos_q[SlotW'(in_sidx)] <= {1'b1, {POS_W{1'b0}}};
        stop_col_q[SlotW'(in_sidx)] <= '0;
      end
    end
  end

  // stop walk
  logic [PtrW-1:0]      ptr_q;
  logic                 rd_hit, rd_end;
  logic [POS_W:0]       rd_raw;
  logic [PosCmpW-1:0]   rd_wide;
  logic [RAMP_BITS-1:0] rd_pos;
  logic [COLOR_W-1:0]   rd_col;

  assign rd_hit  = int'(ptr_q) < STOP_SLOTS;
  assign rd_raw  = rd_hit ? stop_pos_q[ptr_q[SlotW-1:0]] : {1'b1, {POS_W{1'b0}}};
  assign rd_col  = rd_hit ? stop_col_q[ptr_q[SlotW-1:0]] : '0;
  assign rd_end  = rd_raw[POS_W];
  assign rd_wide = PosCmpW'(rd_raw[POS_W-1:0]);
  // saturate positions beyond the table
  assign rd_pos  = (rd_wide > PosCmpW'(RampMax)) ? RAMP_BITS'(RampMax)
                                                 : rd_wide[RAMP_BITS-1:0];

  logic [RAMP_BITS-1:0] cur_pos_q, nxt_pos_q, i_q, d_q;
  logic [COLOR_W-1:0]   cur_col_q, nxt_col_q;
  logic                 nxt_end_q;

  // divider for 255 / d, then incremental weight stepping
  logic [RAMP_BITS-1:0] rem_q, r_q;
  logic [7:0]           quo_q, w_q;
  logic [2:0]           dcnt_q;
  logic [RAMP_BITS:0]   rem_sh, rs;
  logic                 ge, rs_ge;

  assign rem_sh = {rem_q, 1'b1};
  assign ge     = rem_sh >= {1'b0, d_q};
  assign rs     = {1'b0, r_q} + {1'b0, rem_q};
  assign rs_ge  = rs >= {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q  <= '0;
      i_q    <= '0;
      dcnt_q <= '0;
    end else begin
      if (cmd_i.accept) begin
        ptr_q <= '0;
      end else if (cmd_i.load_cur || cmd_i.adv) begin
        ptr_q <= ptr_q + PtrW'(1);
      end
      if (cmd_i.accept) begin
        i_q <= '0;
      end else if (cmd_i.load_nxt) begin
        i_q <= cur_pos_q;
      end else if (cmd_i.clr_wr || cmd_i.fill_wr || cmd_i.blend_wr) begin
        i_q <= i_q + RAMP_BITS'(1);
      end
      if (cmd_i.div_start) begin
        dcnt_q <= '0;
      end else if (cmd_i.div_step) begin
        dcnt_q <= dcnt_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_cur || cmd_i.adv) begin
      cur_pos_q <= cmd_i.adv ? nxt_pos_q : rd_pos;
      cur_col_q <= cmd_i.adv ? nxt_col_q : rd_col;
    end
    if (cmd_i.load_nxt) begin
      nxt_pos_q <= rd_pos;
      nxt_col_q <= rd_col;
      nxt_end_q <= rd_end;
    end
    if (cmd_i.div_start) begin
      d_q   <= nxt_pos_q - cur_pos_q;
      rem_q <= '0;
      quo_q <= '0;
      r_q   <= '0;
      w_q   <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? RAMP_BITS'(rem_sh - {1'b0, d_q}) : rem_sh[RAMP_BITS-1:0];
      quo_q <= {quo_q[6:0], ge};
    end else if (cmd_i.blend_wr) begin
      r_q <= rs_ge ? RAMP_BITS'(rs - {1'b0, d_q}) : rs[RAMP_BITS-1:0];
      w_q <= w_q + quo_q + {7'd0, rs_ge};
    end
  end

  // per channel products, then rounding on the next cycle
  logic [15:0]        pa_q [4];
  logic [15:0]        pb_q [4];
  logic [COLOR_W-1:0] blend_col;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      for (int ch = 0; ch < 4; ch++) begin
        pa_q[ch] <= cur_col_q[ch*8 +: 8] * (CH_MAX - w_q);
        pb_q[ch] <= nxt_col_q[ch*8 +: 8] * w_q;
      end
    end
  end

  always_comb begin
    logic [16:0] t;
    logic [16:0] v;
    blend_col = '0;
    for (int ch = 0; ch < 4; ch++) begin
      t = {1'b0, pa_q[ch]} + {1'b0, pb_q[ch]};
      v = t + (t >> 8) + 17'd1;
      blend_col[ch*8 +: 8] = v[15:8];
    end
  end

  // paint setup and gradient accumulator
  logic signed [COORD_W-1:0] x_q, y_q;
  logic [COUNT_W-1:0]        count_q;
  logic signed [47:0]        mx, my;
  logic signed [31:0]        px_q, py_q, acc_q;
  logic [RunW-1:0]           cnt_q;

  assign mx = x_q * step_x_q;
  assign my = y_q * step_y_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      x_q     <= in_data_i[OFS_X +: COORD_W];
      y_q     <= in_data_i[OFS_Y +: COORD_W];
      count_q <= in_data_i[OFS_COUNT +: COUNT_W];
    end
    if (cmd_i.pt_mul) begin
      px_q <= mx[31:0];
      py_q <= my[31:0];
    end
    if (cmd_i.pt_sum) begin
      acc_q <= px_q + py_q + offset_q;
    end else if (cmd_i.pt_issue) begin
      acc_q <= acc_q + step_x_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.pt_sum) begin
      cnt_q <= (int'(count_q) > MAX_RUN) ? RunW'(MAX_RUN) : RunW'(count_q);
    end else if (cmd_i.pt_issue) begin
      cnt_q <= cnt_q - RunW'(1);
    end
  end

  // fold the gradient coordinate onto the table
  logic signed [IdxW-1:0] idx_s;
  logic                   idx_neg, idx_hi, idx_wrap;
  logic [RAMP_BITS-1:0]   idx_low, raddr;

  if (Sh >= 0) begin : g_shr
    assign idx_s = acc_q >>> Sh;
  end else begin : g_shl
    assign idx_s = {acc_q, {(-Sh){1'b0}}};
  end

  assign idx_neg  = idx_s[IdxW-1];
  assign idx_low  = idx_s[RAMP_BITS-1:0];
  assign idx_hi   = |idx_s[IdxW-1:RAMP_BITS];
  assign idx_wrap = idx_s[RAMP_BITS];

  always_comb begin
    case (spread_q)
      SPREAD_REPEAT:  raddr = idx_low;
      SPREAD_REFLECT: raddr = (!idx_neg && idx_wrap) ? ~idx_low : idx_low;
      default:        raddr = (!idx_neg && idx_hi) ? RAMP_BITS'(RampMax) : idx_low;
    endcase
  end

  // ramp table
  logic                 ram_we;
  logic [COLOR_W-1:0]   ram_wdata, ram_rdata;

  assign ram_we    = cmd_i.clr_wr || cmd_i.fill_wr || cmd_i.blend_wr;
  assign ram_wdata = cmd_i.clr_wr ? COLOR_WHITE : (cmd_i.fill_wr ? cur_col_q : blend_col);

  lgsf_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (RampDepth)
  ) u_ramp (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (i_q),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.pt_issue),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  // two entry output queue, reads issued only against free room
  logic               pend_q, pend_last_q;
  logic [COLOR_W-1:0] oq_col_q  [2];
  logic               oq_last_q [2];
  logic               wp_q, rp_q;
  logic [1:0]         oq_cnt_q;
  logic               pop;
  logic [2:0]         room_use;

  assign pop      = m_tvalid_o && m_tready_i;
  assign room_use = 3'(oq_cnt_q) + 3'(pend_q) - 3'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= 1'b0;
      wp_q     <= 1'b0;
      rp_q     <= 1'b0;
      oq_cnt_q <= '0;
    end else begin
      pend_q <= cmd_i.pt_issue;
      if (pend_q) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      oq_cnt_q <= oq_cnt_q + 2'(pend_q) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pt_issue) pend_last_q <= cnt_q == RunW'(1);
    if (pend_q) begin
      oq_col_q[wp_q]  <= ram_rdata;
      oq_last_q[wp_q] <= pend_last_q;
    end
  end

  assign m_tvalid_o = oq_cnt_q != 2'd0;
  assign m_tdata_o  = oq_col_q[rp_q];
  assign m_tlast_o  = oq_last_q[rp_q];

  assign sts_o.rd_end   = rd_end;
  assign sts_o.i_eq_cur = i_q == cur_pos_q;
  assign sts_o.i_eq_nxt = i_q == nxt_pos_q;
  assign sts_o.i_max    = i_q == RAMP_BITS'(RampMax);
  assign sts_o.nxt_end  = nxt_end_q;
  assign sts_o.nxt_gt   = nxt_pos_q > cur_pos_q;
  assign sts_o.div_last = dcnt_q == 3'd7;
  assign sts_o.cnt_zero = cnt_q == '0;
  assign sts_o.cnt_one  = cnt_q == RunW'(1);
  assign sts_o.credit   = room_use < 3'd2;

endmodule

FILE: sv/linear_gradient_span_fill.sv
// linear_gradient_span_fill: top level of the gradient span painter.
// Depends on lgsf_pkg, lgsf_ctrl, lgsf_dp (which holds lgsf_ram).
//
//  channel   dir  handshake                   payload
//  s_axis    in   s_axis_tvalid/tready        tdata: stop and span fields, tuser: func
//  m_axis    out  m_axis_tvalid/tready        tdata: pixel_color, tlast: last
//  cfg       in   cfg_we_i (no wait)          cfg_idx_i, cfg_data_i
//
// Stop write and no-op: done on acceptance. Paint: setup states (multiply, sum), then one pixel per
// cycle while the sink takes them (one ramp read port, two entry output queue).
// Rebuild: fill up to and including the first stop, per rising segment a divider and then
// a multiply and a blend write per entry, a load and a decision per skipped stop, and the tail fill.
// After reset the table is cleared to white, tready low.
// Results drain in order; a stalled sink holds the queue and stops new reads.
module linear_gradient_span_fill #(
  parameter int RAMP_BITS  = lgsf_pkg::RAMP_BITS_DEF,
  parameter int SCALE_BITS = lgsf_pkg::SCALE_BITS_DEF,
  parameter int STOP_SLOTS = lgsf_pkg::STOP_SLOTS_DEF,
  parameter int MAX_RUN    = lgsf_pkg::MAX_RUN_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // stop_index, stop_valid, stop_pos, stop_color, span_x, span_y, span_count, pad
  input  logic [lgsf_pkg::TDATA_W-1:0]      s_axis_tdata,
  // func
  input  logic [lgsf_pkg::FUNC_W-1:0]       s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // pixel_color
  output logic [lgsf_pkg::COLOR_W-1:0]      m_axis_tdata,
  output logic                              m_axis_tlast,
  input  logic                              cfg_we_i,
  input  logic [lgsf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lgsf_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import lgsf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lgsf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tuser_i  (s_axis_tuser),
    .s_tready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lgsf_dp #(
    .RAMP_BITS  (RAMP_BITS),
    .SCALE_BITS (SCALE_BITS),
    .STOP_SLOTS (STOP_SLOTS),
    .MAX_RUN    (MAX_RUN)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (s_axis_tdata),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tlast_o  (m_axis_tlast)
  );

endmodule

FILE: sv/lgsf_checker.sv
// lgsf_checker: port-level assertions for linear_gradient_span_fill and the
// bind that attaches them. Depends on lgsf_pkg.
module lgsf_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic [lgsf_pkg::FUNC_W-1:0]       s_axis_tuser,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [lgsf_pkg::COLOR_W-1:0]      m_axis_tdata,
  input logic                              m_axis_tlast
);
  import lgsf_pkg::*;

  logic s_xfer;
  assign s_xfer = s_axis_tvalid && s_axis_tready;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output valid dropped under stall");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output payload changed under stall");

  a_paint_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer && (s_axis_tuser == FUNC_PAINT || s_axis_tuser == FUNC_REBUILD)
    |=> !s_axis_tready)
    else $error("ready while a paint or rebuild is under way");

  a_stop_write_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_xfer && (s_axis_tuser == FUNC_WRITE_STOP || s_axis_tuser == FUNC_NOP)
    |=> s_axis_tready)
    else $error("stop write or no-op left the block busy");

endmodule

bind linear_gradient_span_fill lgsf_checker u_lgsf_checker (.*);
